[hw/rtl/aesctr_pkg.sv]
// Package for the AES-128 CTR keystream generator: word types, S-box,
// round helpers and key schedule step. No dependencies.
`default_nettype none
package aesctr_pkg;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned OUT_DEPTH = 2;
	localparam int unsigned NUM_ROUNDS = 10;
	localparam logic [63:0] KEY_LOW_RESET = 64'h0706050403020100;
	localparam logic [63:0] KEY_HIGH_RESET = 64'h0F0E0D0C0B0A0908;
	localparam logic [0:0] REG_KEY_LOW = 1'b0;
	localparam logic [0:0] REG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic       restart;
		logic [4:0] bytes_wanted;
	} in_word_t;

	typedef struct packed {
		logic [63:0] stream_low;
		logic [63:0] stream_high;
		logic [4:0]  valid_count;
	} out_word_t;

	// classified request: counter value and clamped count
	typedef struct packed {
		logic [63:0] ctr;
		logic [4:0]  want;
	} job_t;

	typedef struct packed {
		logic [127:0]  st;
		logic [4:0]    want;
	} stage_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
		8'h20, 8'h40, 8'h80, 8'h1B, 8'h36};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
	endfunction

	// byte k of the state at bits 8k; one round with round key rk, MixColumns skipped when last
	function automatic logic [127:0] aes_round(input logic [127:0] s,
		input logic [127:0] rk, input logic last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				t[k + 4*c] = SBOX[s[8*(k + 4*((c + k) % 4)) +: 8]];
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int k = 0; k < 16; k++)
			r[8*k +: 8] = t[k] ^ rk[8*k +: 8];
		aes_round = r;
	endfunction

	// next round key from previous; rc is the round constant
	function automatic logic [127:0] key_step(input logic [127:0] p,
		input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = p[31:0]; w1 = p[63:32]; w2 = p[95:64]; w3 = p[127:96];
		t = {SBOX[w3[7:0]], SBOX[w3[31:24]], SBOX[w3[23:16]],
			SBOX[w3[15:8]] ^ rc};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		key_step = {w3, w2, w1, w0};
	endfunction
endpackage
`default_nettype wire

[hw/rtl/aesctr_front.sv]
// Front end: accepts requests, applies restart, assigns counter values,
// clamps the byte count and queues jobs. Uses aesctr_pkg.
`default_nettype none
module aesctr_front #(
	parameter int unsigned DEPTH = aesctr_pkg::FIFO_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire aesctr_pkg::in_word_t in_word,
	output logic                     job_vld,
	input  wire logic                job_take,
	output aesctr_pkg::job_t         job
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	aesctr_pkg::job_t mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic [63:0]   ctr_q, ctr_use;
	logic [4:0]    want;
	logic          acc, take;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign acc = push && !full;
	assign job_vld = (cnt_q != '0);
	assign take = job_take && job_vld;
	assign ctr_use = in_word.restart ? 64'd0 : ctr_q;
	assign want = (in_word.bytes_wanted > 5'd16) ? 5'd16 : in_word.bytes_wanted;
	assign job = mem[rd_q];

	always_ff @(posedge clk) begin
		if (acc)
			mem[wr_q] <= '{ctr: ctr_use, want: want};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			ctr_q <= '0;
		end else begin
			if (acc) begin
				ctr_q <= ctr_use + 64'd1;
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
			end
			if (take)
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(acc) - (AW+1)'(take);
		end
	end
endmodule
`default_nettype wire

[hw/rtl/aesctr_keys.sv]
// Key register and schedule: one round key per cycle after reset or a
// write, stored in registers; a new write restarts it. Uses aesctr_pkg.
`default_nettype none
module aesctr_keys (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [0:0]   wr_idx,
	input  wire logic [63:0]  wr_data,
	output logic              busy,
	output logic [127:0]      rk [11]
);
	logic [127:0] rk_q [11];
	logic [3:0]   step_q;
	logic [63:0]  lo, hi;

	assign busy = (step_q != 4'd0);
	assign rk = rk_q;
	assign lo = (wr_en && wr_idx == aesctr_pkg::REG_KEY_LOW) ? wr_data : rk_q[0][63:0];
	assign hi = (wr_en && wr_idx == aesctr_pkg::REG_KEY_HIGH) ? wr_data : rk_q[0][127:64];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rk_q[0] <= {aesctr_pkg::KEY_HIGH_RESET, aesctr_pkg::KEY_LOW_RESET};
			for (int i = 1; i < 11; i++)
				rk_q[i] <= '0;
			step_q <= 4'd1;
		end else if (wr_en) begin
			rk_q[0] <= {hi, lo};
			step_q <= 4'd1;
		end else if (step_q != 4'd0) begin
			rk_q[step_q] <= aesctr_pkg::key_step(rk_q[step_q - 4'd1],
				aesctr_pkg::RCON[step_q - 4'd1]);
			step_q <= (step_q == 4'd10) ? 4'd0 : step_q + 4'd1;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/aesctr_back.sv]
// Back end: key-addition stage, ten-stage round pipeline, byte masking
// and a result queue with credit flow control. Uses aesctr_pkg.
`default_nettype none
module aesctr_back #(
	parameter int unsigned ODEPTH = aesctr_pkg::OUT_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_vld,
	output logic                    job_take,
	input  wire aesctr_pkg::job_t   job,
	input  wire logic [127:0]       rk [11],
	input  wire logic               hold,
	output logic                    empty,
	input  wire logic               pop,
	output aesctr_pkg::out_word_t   out_word
);
	localparam int unsigned NS = aesctr_pkg::NUM_ROUNDS;
	localparam int unsigned QD = NS + ODEPTH;
	localparam int unsigned QW = $clog2(QD);
	localparam int unsigned CW = $clog2(QD + 1);

	aesctr_pkg::stage_t st_s [NS + 1];
	logic [NS:0]   vld_s;
	aesctr_pkg::out_word_t q_mem [QD];
	aesctr_pkg::out_word_t res;
	logic [QW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q, busy_q;
	logic          deq;
	logic [127:0]  ks;

	// credits: queue entries plus jobs in flight
	assign job_take = job_vld && !hold && (busy_q < CW'(QD));
	assign empty = (cnt_q == '0);
	assign deq = pop && !empty;
	assign out_word = q_mem[rd_q];

	always_comb begin
		ks = st_s[NS].st;
		for (int k = 0; k < 16; k++)
			if (5'(k) >= st_s[NS].want)
				ks[8*k +: 8] = 8'h00;
		res = '{stream_low: ks[63:0], stream_high: ks[127:64],
			valid_count: st_s[NS].want};
	end

	always_ff @(posedge clk) begin
		st_s[0].st <= {64'd0, job.ctr} ^ rk[0];
		st_s[0].want <= job.want;
		for (int r = 1; r <= NS; r++) begin
			st_s[r].st <= aesctr_pkg::aes_round(st_s[r-1].st, rk[r], r == NS);
			st_s[r].want <= st_s[r-1].want;
		end
		if (vld_s[NS])
			q_mem[wr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			busy_q <= '0;
		end else begin
			vld_s <= {vld_s[NS-1:0], job_take};
			if (vld_s[NS])
				wr_q <= (wr_q == QW'(QD-1)) ? '0 : wr_q + QW'(1);
			if (deq)
				rd_q <= (rd_q == QW'(QD-1)) ? '0 : rd_q + QW'(1);
			cnt_q <= cnt_q + CW'(vld_s[NS]) - CW'(deq);
			busy_q <= busy_q + CW'(job_take) - CW'(deq);
		end
	end
endmodule
`default_nettype wire

[hw/rtl/aes128_ctr_keystream_generator_core.sv]
// AES-128 CTR keystream generator top level. Uses aesctr_pkg, aesctr_front,
// aesctr_keys, aesctr_back.
// Throughput: one word per cycle through the ten-stage round pipeline
// unless the key schedule, a key write or missing queue credits hold jobs back.
// Reset: key returns to its reset value, counter to zero; the key schedule
// runs after reset or a key write, and no job starts while it runs.
`default_nettype none
module aes128_ctr_keystream_generator_core #(
	parameter int unsigned FIFO_DEPTH = aesctr_pkg::FIFO_DEPTH,
	parameter int unsigned OUT_DEPTH = aesctr_pkg::OUT_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire aesctr_pkg::in_word_t  in_word,
	output logic                      empty,
	input  wire logic                 pop,
	output aesctr_pkg::out_word_t     out_word,
	input  wire logic                 cfg_we,
	input  wire logic [0:0]           cfg_idx,
	input  wire logic [63:0]          cfg_data
);
	logic             job_vld, job_take, kbusy;
	aesctr_pkg::job_t job;
	logic [127:0]     rk [11];

	aesctr_front #(.DEPTH(FIFO_DEPTH)) u_front (
		.clk, .arst_n, .push, .full, .in_word,
		.job_vld, .job_take, .job
	);

	aesctr_keys u_keys (
		.clk, .arst_n, .wr_en(cfg_we), .wr_idx(cfg_idx), .wr_data(cfg_data),
		.busy(kbusy), .rk
	);

	aesctr_back #(.ODEPTH(OUT_DEPTH)) u_back (
		.clk, .arst_n, .job_vld, .job_take, .job, .rk,
		.hold(kbusy || cfg_we), .empty, .pop, .out_word
	);

	a_no_take_in_sched: assert property (@(posedge clk) disable iff (!arst_n)
		kbusy |-> !job_take) else $error("job started during key schedule");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_word.valid_count <= 5'd16)) else $error("count out of range");
	a_take_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_vld) else $error("take without job");
endmodule
`default_nettype wire
